### rtl/rcs_pkg.sv
package rcs_pkg;

    typedef enum logic [1:0] {
        CMD_ARRIVE     = 2'd0,
        CMD_SERVE      = 2'd1,
        CMD_LOAD_PROF  = 2'd2,
        CMD_LOAD_CLASS = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_QUEUED   = 2'd2,
        ST_RELEASED = 2'd3
    } status_t;

    localparam logic [2:0] REG_HEADER_BITS   = 3'd0;
    localparam logic [2:0] REG_MAX_QUEUE_LEN = 3'd1;
    localparam logic [2:0] REG_MAX_BACKLOG   = 3'd2;
    localparam logic [2:0] REG_WINDOW_SIZE   = 3'd3;
    localparam logic [2:0] REG_MIN_WPB       = 3'd4;
    localparam logic [2:0] REG_MAX_WPB       = 3'd5;
    localparam logic [2:0] REG_PROFILE_COUNT = 3'd6;

    localparam int TS_W      = 48;
    localparam int INS_W     = 17;
    localparam int WAIT_W    = 49;
    localparam int MARK_W    = 16;
    localparam int BACKLOG_W = 63;
    localparam int IN_W      = 160;
    localparam int OUT_W     = 80;
    localparam int CUM_W     = 20;

    // Control of a one-port-write, one-port-read synchronous memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

### rtl/rcs_queue_mem.sv
module rcs_queue_mem #(
    parameter int DEPTH = 128
) (
    input  logic                                          aclk,
    input  rcs_pkg::mem_ctl_t                             ctl,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
    input  logic [rcs_pkg::WAIT_W+rcs_pkg::MARK_W-1:0]    wr_data,
    output logic [rcs_pkg::WAIT_W+rcs_pkg::MARK_W-1:0]    rd_data
);
    import rcs_pkg::*;

    logic [WAIT_W+MARK_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/rcs_class_mem.sv
module rcs_class_mem #(
    parameter int ADDR_W = 5
) (
    input  logic                  aclk,
    input  rcs_pkg::mem_ctl_t     ctl,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [ADDR_W-1:0]     rd_addr,
    input  logic [31:0]           wr_data,
    output logic [31:0]           rd_data
);
    import rcs_pkg::*;

    // Each entry: probability in the upper half, urgency and cherish below.
    logic [31:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/rcs_rate_div.sv
module rcs_rate_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 48
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    import rcs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;

    // One restoring step per cycle; the dividend shifts out as quotient bits shift in.
    always_comb begin
        rem_sh = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
            rem_reg <= q_bit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

### rtl/rate_adaptive_class_shaper.sv
// Rate-adaptive class shaper.
// Words enter on the s_ channel: s_tuser carries the command (arrive, serve
// timer fired, load profile, load class) and s_tdata the packet and table
// fields. Configuration registers are written on the cfg_ channel, which is
// always ready and must only be used while the shaper is idle.
// Arrivals and serve events each produce exactly one word on the m_ channel:
// m_tuser is the status, m_tdata holds the released mark and the delay with
// which the serve timer must be armed. Table loads produce no word.
// Queued waits and marks live in one synchronous memory, class entries in a
// second; every item is a read, modify and write back of the shaper state.
// A serve releases the queue head, if any. An arrival forms its wait in S_WPB,
// S_SUM and S_WAIT and is checked in S_CHECK, where a drop ends it. A kept
// arrival runs the serial rate divider once the window is full and the span
// is nonzero, reads each class it visits from the class memory in S_CLS_RD
// and S_CLS, queues in S_COMMIT and, if not serving, releases through
// S_REL_RD and S_REL. One item is processed at a time. The result sits in
// an output register, so a stalled receiver only holds the shaper once a
// second result is ready. A synchronous reset empties the queue, the window
// and the backlog and reloads the register defaults; the profile and class
// tables must be loaded before traffic.
module rate_adaptive_class_shaper #(
    parameter int QUEUE_DEPTH = 128,
    parameter int WINDOW_MAX  = 15,
    parameter int PROFILES    = 4,
    parameter int CLASSES     = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // pdu_bits, timestamp, queue_len, rand_wait, rand_class, table_profile,
    // table_slot, table_value, table_urgency, table_cherish (lowest first)
    input  logic [rcs_pkg::IN_W-1:0]  s_tdata,
    // cmd
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // out_urgency, out_cherish, delay_valid, delay (lowest first)
    output logic [rcs_pkg::OUT_W-1:0] m_tdata,
    // status
    output logic [1:0]                m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [63:0]               cfg_data
);
    import rcs_pkg::*;

    localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int RING  = WINDOW_MAX + 1;
    localparam int RW    = $clog2(RING);
    localparam int RCW   = $clog2(RING + 1);
    localparam int SUM_W = $clog2(RING * 131071 + 1);
    localparam int DIV_W = SUM_W + 16;
    localparam int PW    = (PROFILES > 1) ? $clog2(PROFILES) : 1;
    localparam int CLW   = (CLASSES > 1) ? $clog2(CLASSES) : 1;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_WPB    = 13'b0000000000010,
        S_SUM    = 13'b0000000000100,
        S_WAIT   = 13'b0000000001000,
        S_CHECK  = 13'b0000000010000,
        S_DIV    = 13'b0000000100000,
        S_CLS_RD = 13'b0000001000000,
        S_CLS    = 13'b0000010000000,
        S_COMMIT = 13'b0000100000000,
        S_REL_RD = 13'b0001000000000,
        S_REL    = 13'b0010000000000,
        S_OUT    = 13'b0100000000000,
        S_SPARE  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0]          header_bits_reg;
    logic [7:0]           max_queue_len_reg;
    logic [BACKLOG_W-1:0] max_backlog_reg;
    logic [3:0]           window_size_reg;
    logic [31:0]          min_wpb_reg;
    logic [31:0]          max_wpb_reg;
    logic [2:0]           profile_count_reg;

    // Shaper state.
    logic [PCW-1:0]       pending_reg;
    logic [QW-1:0]        qhead_reg;
    logic                 running_reg;
    logic [BACKLOG_W-1:0] backlog_reg;
    logic [RCW-1:0]       wcount_reg;
    logic [RW-1:0]        rhead_reg;
    logic [SUM_W-1:0]     wsum_reg;
    logic [TS_W-1:0]      time_ring [RING];
    logic [INS_W-1:0]     size_ring [RING];
    logic [34:0]          profile_regs [PROFILES];

    // Item in flight.
    logic [INS_W-1:0]     ins_reg;
    logic [TS_W-1:0]      ts_reg;
    logic [7:0]           qlen_reg;
    logic [15:0]          rwait_reg;
    logic [15:0]          rclass_reg;
    logic [47:0]          prod_reg;
    logic [31:0]          wpb_reg;
    logic [WAIT_W-1:0]    w_reg;
    logic [PW-1:0]        prof_reg;
    logic [CLW-1:0]       k_reg;
    logic [CUM_W-1:0]     cum_reg;
    logic [MARK_W-1:0]    mark_reg;

    // Staged result and output register.
    logic [1:0]           res_status_reg;
    logic [7:0]           res_urg_reg;
    logic [7:0]           res_cher_reg;
    logic                 res_dv_reg;
    logic [BACKLOG_W-1:0] res_delay_reg;
    logic                 m_tvalid_reg;
    logic [1:0]           m_status_reg;
    logic [7:0]           m_urg_reg;
    logic [7:0]           m_cher_reg;
    logic                 m_dv_reg;
    logic [BACKLOG_W-1:0] m_delay_reg;

    // Input fields.
    logic [15:0] in_pdu;
    logic [47:0] in_ts;
    logic [7:0]  in_qlen;
    logic [15:0] in_rwait;
    logic [15:0] in_rclass;
    logic [1:0]  in_prof;
    logic [2:0]  in_slot;
    logic [31:0] in_value;
    logic [7:0]  in_urg;
    logic [7:0]  in_cher;

    assign in_pdu    = s_tdata[15:0];
    assign in_ts     = s_tdata[63:16];
    assign in_qlen   = s_tdata[71:64];
    assign in_rwait  = s_tdata[87:72];
    assign in_rclass = s_tdata[103:88];
    assign in_prof   = s_tdata[105:104];
    assign in_slot   = s_tdata[108:106];
    assign in_value  = s_tdata[140:109];
    assign in_urg    = s_tdata[148:141];
    assign in_cher   = s_tdata[156:149];

    logic s_fire;
    logic out_free;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Clamped configuration.
    logic [8:0]     ws_wide;
    logic [RCW-1:0] ws_eff;
    logic [4:0]     pc_eff;
    always_comb begin
        ws_wide = {5'd0, window_size_reg};
        if (ws_wide < 9'd4) begin
            ws_wide = 9'd4;
        end
        if (ws_wide > 9'(WINDOW_MAX)) begin
            ws_wide = 9'(WINDOW_MAX);
        end
        ws_eff = RCW'(ws_wide);
        pc_eff = {2'd0, profile_count_reg};
        if (pc_eff < 5'd1) begin
            pc_eff = 5'd1;
        end
        if (pc_eff > 5'(PROFILES)) begin
            pc_eff = 5'(PROFILES);
        end
    end

    // Wait per bit: the sign of max - min picks add or subtract.
    logic        wpb_up;
    logic [31:0] wpb_diff;
    assign wpb_up   = (max_wpb_reg >= min_wpb_reg);
    assign wpb_diff = wpb_up ? (max_wpb_reg - min_wpb_reg) : (min_wpb_reg - max_wpb_reg);

    // Drop check and window span.
    logic [63:0]     backlog_sum;
    logic            drop;
    logic [TS_W-1:0] span;
    assign backlog_sum = {1'b0, backlog_reg} + 64'(w_reg);
    assign drop = (qlen_reg >= max_queue_len_reg)
               || (backlog_sum > {1'b0, max_backlog_reg})
               || (pending_reg >= PCW'(QUEUE_DEPTH));
    assign span = ts_reg - time_ring[rhead_reg];

    logic             win_full;
    logic [RW-1:0]    rhead_inc;
    assign win_full  = (wcount_reg > ws_eff);
    assign rhead_inc = (32'(rhead_reg) + 1 >= RING) ? '0 : RW'(32'(rhead_reg) + 1);

    // Rate divider.
    logic             div_start;
    logic             div_done;
    logic [DIV_W-1:0] div_q;
    assign div_start = (state_reg == S_CHECK) && !drop && win_full && (span != '0);

    rcs_rate_div #(
        .NUM_W (DIV_W),
        .DEN_W (TS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({wsum_reg, 16'd0}),
        .divisor  (span),
        .done     (div_done),
        .quotient (div_q)
    );

    // First profile in use whose threshold exceeds the rate, else the last.
    logic [PW-1:0] prof_sel;
    logic          prof_found;
    always_comb begin
        prof_sel   = PW'(pc_eff - 5'd1);
        prof_found = 1'b0;
        for (int p = 0; p < PROFILES; p++) begin
            if (!prof_found && (5'(p) < pc_eff)
                && (DIV_W'(profile_regs[p][31:0]) > div_q)) begin
                prof_sel   = PW'(p);
                prof_found = 1'b1;
            end
        end
    end

    // Class memory.
    mem_ctl_t    cls_ctl;
    logic [31:0] cls_rd_data;
    logic [31:0] cls_wr_data;
    logic [15:0] prob_sat;
    logic        load_ok_prof;
    logic        load_ok_class;
    assign load_ok_prof  = ({3'd0, in_prof} < 5'(PROFILES));
    assign load_ok_class = load_ok_prof && ({2'd0, in_slot} < 5'(CLASSES));
    assign prob_sat      = (in_value > 32'h0000_FFFF) ? 16'hFFFF : in_value[15:0];
    assign cls_wr_data   = {prob_sat, in_urg, in_cher};
    assign cls_ctl.wr_en = s_fire && (s_tuser == CMD_LOAD_CLASS) && load_ok_class;
    assign cls_ctl.rd_en = (state_reg == S_CLS_RD);

    rcs_class_mem #(
        .ADDR_W (PW + CLW)
    ) u_cls (
        .aclk    (aclk),
        .ctl     (cls_ctl),
        .wr_addr ({PW'(in_prof), CLW'(in_slot)}),
        .rd_addr ({prof_reg, k_reg}),
        .wr_data (cls_wr_data),
        .rd_data (cls_rd_data)
    );

    // Class scan step.
    logic [CUM_W-1:0] cum_next;
    logic [4:0]       last_k;
    logic             cls_hit;
    always_comb begin
        cum_next = cum_reg + CUM_W'(cls_rd_data[31:16]);
        last_k   = {2'd0, profile_regs[prof_reg][34:32]};
        if (last_k > 5'(CLASSES - 1)) begin
            last_k = 5'(CLASSES - 1);
        end
        cls_hit = (CUM_W'(rclass_reg) <= cum_next) || (5'(k_reg) == last_k);
    end

    // Queue memory.
    mem_ctl_t                  q_ctl;
    logic [WAIT_W+MARK_W-1:0]  q_rd_data;
    logic [QW:0]               tail_sum;
    logic [QW-1:0]             qtail;
    logic [QW-1:0]             qhead_inc;
    assign tail_sum  = (QW+1)'(qhead_reg) + (QW+1)'(pending_reg);
    assign qtail     = (32'(tail_sum) >= QUEUE_DEPTH) ? QW'(32'(tail_sum) - QUEUE_DEPTH)
                                                      : QW'(tail_sum);
    assign qhead_inc = (32'(qhead_reg) + 1 >= QUEUE_DEPTH) ? '0 : QW'(32'(qhead_reg) + 1);
    assign q_ctl.wr_en = (state_reg == S_COMMIT);
    assign q_ctl.rd_en = (state_reg == S_REL_RD) && (pending_reg != '0);

    rcs_queue_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .ctl     (q_ctl),
        .wr_addr (qtail),
        .rd_addr (qhead_reg),
        .wr_data ({w_reg, mark_reg}),
        .rd_data (q_rd_data)
    );

    // Ring tail for the window push, after any pop in the check step.
    logic [RW:0]   rtail_sum;
    logic [RW-1:0] rtail;
    assign rtail_sum = (RW+1)'(rhead_reg) + (RW+1)'(wcount_reg);
    assign rtail     = (32'(rtail_sum) >= RING) ? RW'(32'(rtail_sum) - RING) : RW'(rtail_sum);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == CMD_ARRIVE) begin
                        state_next = S_WPB;
                    end else if (s_tuser == CMD_SERVE) begin
                        state_next = S_REL_RD;
                    end
                end
            end
            S_WPB:   state_next = S_SUM;
            S_SUM:   state_next = S_WAIT;
            S_WAIT:  state_next = S_CHECK;
            S_CHECK: begin
                if (drop) begin
                    state_next = S_OUT;
                end else if (div_start) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_CLS_RD;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_CLS_RD;
                end
            end
            S_CLS_RD: state_next = S_CLS;
            S_CLS:    state_next = cls_hit ? S_COMMIT : S_CLS_RD;
            S_COMMIT: state_next = running_reg ? S_OUT : S_REL_RD;
            S_REL_RD: state_next = (pending_reg == '0) ? S_OUT : S_REL;
            S_REL:    state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            header_bits_reg   <= 16'd8;
            max_queue_len_reg <= 8'd100;
            max_backlog_reg   <= 63'd16777216000000;
            window_size_reg   <= 4'd10;
            min_wpb_reg       <= 32'd15099494;
            max_wpb_reg       <= 32'd18454938;
            profile_count_reg <= 3'd1;
            pending_reg       <= '0;
            qhead_reg         <= '0;
            running_reg       <= 1'b0;
            backlog_reg       <= '0;
            wcount_reg        <= '0;
            rhead_reg         <= '0;
            wsum_reg          <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HEADER_BITS:   header_bits_reg   <= cfg_data[15:0];
                    REG_MAX_QUEUE_LEN: max_queue_len_reg <= cfg_data[7:0];
                    REG_MAX_BACKLOG:   max_backlog_reg   <= cfg_data[62:0];
                    REG_WINDOW_SIZE:   window_size_reg   <= cfg_data[3:0];
                    REG_MIN_WPB:       min_wpb_reg       <= cfg_data[31:0];
                    REG_MAX_WPB:       max_wpb_reg       <= cfg_data[31:0];
                    REG_PROFILE_COUNT: profile_count_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_fire && s_tuser == CMD_SERVE) begin
                running_reg <= 1'b1;
            end
            // The oldest arrival leaves the window once it is full.
            if (state_reg == S_CHECK && !drop && win_full) begin
                wsum_reg   <= wsum_reg - SUM_W'(size_ring[rhead_reg]);
                rhead_reg  <= rhead_inc;
                wcount_reg <= wcount_reg - 1'b1;
            end
            if (state_reg == S_COMMIT) begin
                pending_reg <= pending_reg + 1'b1;
                backlog_reg <= backlog_reg + BACKLOG_W'(w_reg);
                running_reg <= 1'b1;
                if (32'(wcount_reg) < RING) begin
                    wsum_reg   <= wsum_reg + SUM_W'(ins_reg);
                    wcount_reg <= wcount_reg + 1'b1;
                end
            end
            if (state_reg == S_REL_RD && pending_reg == '0) begin
                running_reg <= 1'b0;
            end
            if (state_reg == S_REL) begin
                qhead_reg   <= qhead_inc;
                pending_reg <= pending_reg - 1'b1;
                backlog_reg <= backlog_reg - BACKLOG_W'(q_rd_data[WAIT_W+MARK_W-1:MARK_W]);
            end
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath and table storage.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ins_reg    <= INS_W'(in_pdu) + INS_W'(header_bits_reg);
            ts_reg     <= in_ts;
            qlen_reg   <= in_qlen;
            rwait_reg  <= in_rwait;
            rclass_reg <= in_rclass;
            if (s_tuser == CMD_LOAD_PROF && load_ok_prof) begin
                profile_regs[PW'(in_prof)] <= {in_slot, in_value};
            end
        end
        if (state_reg == S_WPB) begin
            prod_reg <= 48'(wpb_diff) * 48'(rwait_reg);
        end
        if (state_reg == S_SUM) begin
            wpb_reg <= wpb_up ? (min_wpb_reg + prod_reg[47:16])
                              : (min_wpb_reg - prod_reg[47:16]);
        end
        if (state_reg == S_WAIT) begin
            w_reg <= WAIT_W'(ins_reg) * WAIT_W'(wpb_reg);
        end
        if (state_reg == S_CHECK) begin
            k_reg    <= '0;
            cum_reg  <= '0;
            prof_reg <= win_full ? PW'(pc_eff - 5'd1) : '0;
            res_status_reg <= ST_DROPPED;
            res_urg_reg    <= '0;
            res_cher_reg   <= '0;
            res_dv_reg     <= 1'b0;
            res_delay_reg  <= '0;
        end
        if (state_reg == S_DIV && div_done) begin
            prof_reg <= prof_sel;
        end
        if (state_reg == S_CLS) begin
            cum_reg  <= cum_next;
            k_reg    <= k_reg + 1'b1;
            mark_reg <= cls_rd_data[15:0];
        end
        if (state_reg == S_COMMIT) begin
            if (32'(wcount_reg) < RING) begin
                time_ring[rtail] <= ts_reg;
                size_ring[rtail] <= ins_reg;
            end
            res_status_reg <= ST_QUEUED;
        end
        if (state_reg == S_REL_RD) begin
            res_status_reg <= ST_NONE;
            res_urg_reg    <= '0;
            res_cher_reg   <= '0;
            res_dv_reg     <= 1'b0;
            res_delay_reg  <= '0;
        end
        if (state_reg == S_REL) begin
            res_status_reg <= ST_RELEASED;
            res_urg_reg    <= q_rd_data[15:8];
            res_cher_reg   <= q_rd_data[7:0];
            res_dv_reg     <= 1'b1;
            res_delay_reg  <= BACKLOG_W'(q_rd_data[WAIT_W+MARK_W-1:MARK_W]);
        end
        if (state_reg == S_OUT && out_free) begin
            m_status_reg <= res_status_reg;
            m_urg_reg    <= res_urg_reg;
            m_cher_reg   <= res_cher_reg;
            m_dv_reg     <= res_dv_reg;
            m_delay_reg  <= res_delay_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_delay_reg, m_dv_reg, m_cher_reg, m_urg_reg};

endmodule

### rtl/rcs_checker.sv
module rcs_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [1:0]                s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rcs_pkg::OUT_W-1:0] m_tdata,
    input logic [1:0]                m_tuser
);
    import rcs_pkg::*;

    // A word held back by the receiver stays unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // A release always arms the timer; other words carry no mark or delay.
    a_release_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_RELEASED |-> m_tdata[16])
        else $error("release without timer arm");

    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_RELEASED |-> m_tdata == '0)
        else $error("non-release word carries mark or delay");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // An arrival or a serve keeps the input closed in the following cycle;
    // table loads complete at once.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_ARRIVE || s_tuser == CMD_SERVE)
        |=> !s_tready)
        else $error("input taken while an item is in work");

endmodule

bind rate_adaptive_class_shaper rcs_checker u_rcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the rate-adaptive class shaper.
// Every word accepted on the s_ channel is also applied to a local shaper
// model kept in this module. Arrivals and serve events each add one
// expected result word. Each word taken from the m_ channel is compared
// field by field with the oldest expected word.
module tb_top;
    import rcs_pkg::*;

    localparam int Q_DEPTH   = 128;
    localparam int WIN_MAX   = 15;
    localparam int RING_SIZE = WIN_MAX + 1;
    localparam int N_PROF    = 4;
    localparam int N_CLASS   = 8;
    // Longer than the slowest arrival, so this covers any word that is still
    // being worked on after the last result.
    localparam int SETTLE    = 100;
    localparam int STALL_LIM = 20000;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] pdu_bits;
        logic [47:0] stamp;
        logic [7:0]  qlen;
        logic [15:0] rnd_wait;
        logic [15:0] rnd_class;
        logic [1:0]  tprof;
        logic [2:0]  tslot;
        logic [31:0] tvalue;
        logic [7:0]  turg;
        logic [7:0]  tcher;
    } shaper_word_t;

    typedef struct {
        status_t     status;
        logic [7:0]  urgency;
        logic [7:0]  cherish;
        logic        dly_valid;
        logic [62:0] dly;
    } shaper_out_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [1:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [2:0]       cfg_index = '0;
    logic [63:0]      cfg_data = '0;

    rate_adaptive_class_shaper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Local copy of the shaper registers, reset values included.
    logic [15:0] hdr_bits   = 16'd8;
    logic [7:0]  qlen_limit = 8'd100;
    logic [62:0] blog_limit = 63'd16777216000000;
    logic [3:0]  win_cfg    = 4'd10;
    logic [31:0] wpb_lo     = 32'd15099494;
    logic [31:0] wpb_hi     = 32'd18454938;
    logic [2:0]  prof_cfg   = 3'd1;

    // Local copy of the shaper state.
    logic [63:0] wait_q [Q_DEPTH];
    logic [15:0] mark_q [Q_DEPTH];
    int          pend_cnt = 0;
    int          q_head = 0;
    bit          serving = 1'b0;
    logic [63:0] backlog_ticks = '0;
    logic [47:0] arr_time [RING_SIZE];
    logic [16:0] arr_size [RING_SIZE];
    int          win_cnt = 0;
    int          ring_rd = 0;
    logic [31:0] win_bits = '0;
    logic [34:0] prof_tab [N_PROF];
    logic [31:0] class_tab [N_PROF*N_CLASS];

    shaper_out_t expected_words [$];
    int          mismatches = 0;
    int          n_arrivals = 0;
    int          n_drops = 0;
    int          n_released = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    int          rdy_hold = 0;
    logic [47:0] clock_ticks = '0;

    // Take the oldest queued packet off the model queue, or stop serving.
    function automatic shaper_out_t release_head();
        shaper_out_t r;
        r.status = ST_NONE;
        r.urgency = '0;
        r.cherish = '0;
        r.dly_valid = 1'b0;
        r.dly = '0;
        if (pend_cnt == 0) begin
            serving = 1'b0;
        end else begin
            r.status = ST_RELEASED;
            r.urgency = mark_q[q_head][15:8];
            r.cherish = mark_q[q_head][7:0];
            r.dly_valid = 1'b1;
            r.dly = wait_q[q_head][62:0];
            backlog_ticks = backlog_ticks - wait_q[q_head];
            q_head = (q_head + 1 >= Q_DEPTH) ? 0 : q_head + 1;
            pend_cnt--;
        end
        return r;
    endfunction

    // Cumulative probability walk over the classes of one profile.
    function automatic logic [15:0] choose_mark(int p, logic [15:0] rnd);
        int          n;
        logic [31:0] cum;
        n = int'(prof_tab[p][34:32]) + 1;
        cum = '0;
        if (n > N_CLASS) n = N_CLASS;
        for (int k = 0; k < n; k++) begin
            cum = cum + class_tab[p*N_CLASS+k][31:16];
            if ({16'd0, rnd} <= cum) return class_tab[p*N_CLASS+k][15:0];
        end
        return class_tab[p*N_CLASS+n-1][15:0];
    endfunction

    // Applies one accepted word to the model. Returns 1 with the expected
    // result word for arrivals and serves, 0 for table loads.
    function automatic bit shaper_predict(shaper_word_t w, output shaper_out_t r);
        logic [63:0] ins, wpb, wt, span, rate;
        logic [47:0] span48;
        int          ws, pc, prof, slot_at;
        r.status = ST_NONE;
        r.urgency = '0;
        r.cherish = '0;
        r.dly_valid = 1'b0;
        r.dly = '0;
        case (w.cmd)
            CMD_LOAD_PROF: begin
                prof_tab[w.tprof] = {w.tslot, w.tvalue};
                return 1'b0;
            end
            CMD_LOAD_CLASS: begin
                class_tab[int'(w.tprof)*N_CLASS+int'(w.tslot)] =
                    {(w.tvalue > 32'hFFFF) ? 16'hFFFF : w.tvalue[15:0], w.turg, w.tcher};
                return 1'b0;
            end
            CMD_SERVE: begin
                serving = 1'b1;
                r = release_head();
                return 1'b1;
            end
            default: begin
            end
        endcase
        ins = 64'(w.pdu_bits) + 64'(hdr_bits);
        if (wpb_hi >= wpb_lo)
            wpb = 64'(wpb_lo) + ((64'(wpb_hi - wpb_lo) * 64'(w.rnd_wait)) >> 16);
        else
            wpb = 64'(wpb_lo) - ((64'(wpb_lo - wpb_hi) * 64'(w.rnd_wait)) >> 16);
        wt = ins * wpb;
        if (w.qlen >= qlen_limit || wt + backlog_ticks > 64'(blog_limit) ||
            pend_cnt >= Q_DEPTH) begin
            r.status = ST_DROPPED;
            return 1'b1;
        end
        ws = int'(win_cfg);
        if (ws < 4) ws = 4;
        if (ws > WIN_MAX) ws = WIN_MAX;
        pc = int'(prof_cfg);
        if (pc < 1) pc = 1;
        if (pc > N_PROF) pc = N_PROF;
        if (win_cnt <= ws) begin
            prof = 0;
        end else begin
            // The span wraps at the timestamp width.
            span48 = w.stamp - arr_time[ring_rd];
            span = 64'(span48);
            prof = pc - 1;
            if (span != 0) begin
                rate = (64'(win_bits) << 16) / span;
                for (int p = 0; p < pc; p++) begin
                    if (64'(prof_tab[p][31:0]) > rate) begin
                        prof = p;
                        break;
                    end
                end
            end
            win_bits = win_bits - 32'(arr_size[ring_rd]);
            ring_rd = (ring_rd + 1 >= RING_SIZE) ? 0 : ring_rd + 1;
            win_cnt--;
        end
        slot_at = (q_head + pend_cnt) % Q_DEPTH;
        wait_q[slot_at] = wt;
        mark_q[slot_at] = choose_mark(prof, w.rnd_class);
        pend_cnt++;
        backlog_ticks = backlog_ticks + wt;
        if (win_cnt < RING_SIZE) begin
            slot_at = (ring_rd + win_cnt) % RING_SIZE;
            arr_time[slot_at] = w.stamp;
            arr_size[slot_at] = ins[16:0];
            win_bits = win_bits + 32'(ins[16:0]);
            win_cnt++;
        end
        if (!serving) begin
            serving = 1'b1;
            r = release_head();
        end else begin
            r.status = ST_QUEUED;
        end
        return 1'b1;
    endfunction

    // Sends one word, optionally after an idle burst. With typed set, the
    // expected result is the hand-written one instead of the model's.
    task automatic send_word(shaper_word_t w, bit typed = 1'b0,
                             status_t typed_status = ST_NONE);
        shaper_out_t r;
        bit          has;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= w.cmd;
        s_tdata <= {3'b000, w.tcher, w.turg, w.tvalue, w.tslot, w.tprof,
                    w.rnd_class, w.rnd_wait, w.qlen, w.stamp, w.pdu_bits};
        do @(posedge aclk); while (!s_tready);
        has = shaper_predict(w, r);
        if (has) begin
            if (typed) begin
                r.status = typed_status;
                r.urgency = '0;
                r.cherish = '0;
                r.dly_valid = 1'b0;
                r.dly = '0;
            end
            expected_words.insert(expected_words.size(), r);
            if (w.cmd == CMD_ARRIVE) begin
                n_arrivals++;
                if (r.status == ST_DROPPED) n_drops++;
            end
        end
    endtask

    // Holds the sender off until every expected word has come back, then
    // waits out the settle time before returning.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Register writes happen only while the shaper is idle.
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_HEADER_BITS:   hdr_bits = value[15:0];
            REG_MAX_QUEUE_LEN: qlen_limit = value[7:0];
            REG_MAX_BACKLOG:   blog_limit = value[62:0];
            REG_WINDOW_SIZE:   win_cfg = value[3:0];
            REG_MIN_WPB:       wpb_lo = value[31:0];
            REG_MAX_WPB:       wpb_hi = value[31:0];
            REG_PROFILE_COUNT: prof_cfg = value[2:0];
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] hb, logic [7:0] ql, logic [62:0] bl,
                             logic [3:0] ws, logic [31:0] lo, logic [31:0] hi,
                             logic [2:0] pc);
        write_reg(REG_HEADER_BITS, 64'(hb));
        write_reg(REG_MAX_QUEUE_LEN, 64'(ql));
        write_reg(REG_MAX_BACKLOG, 64'(bl));
        write_reg(REG_WINDOW_SIZE, 64'(ws));
        write_reg(REG_MIN_WPB, 64'(lo));
        write_reg(REG_MAX_WPB, 64'(hi));
        write_reg(REG_PROFILE_COUNT, 64'(pc));
    endtask

    function automatic shaper_word_t traffic_word(cmd_t c, logic [15:0] pdu,
                                                  logic [47:0] ts, logic [7:0] ql,
                                                  logic [15:0] rw, logic [15:0] rc);
        shaper_word_t w;
        w.cmd = c;
        w.pdu_bits = pdu;
        w.stamp = ts;
        w.qlen = ql;
        w.rnd_wait = rw;
        w.rnd_class = rc;
        w.tprof = 2'($urandom);
        w.tslot = 3'($urandom);
        w.tvalue = $urandom;
        w.turg = 8'($urandom);
        w.tcher = 8'($urandom);
        return w;
    endfunction

    function automatic shaper_word_t table_word(cmd_t c, logic [1:0] p, logic [2:0] s,
                                                logic [31:0] v, logic [7:0] u,
                                                logic [7:0] ch);
        shaper_word_t w;
        w = traffic_word(c, 16'($urandom), 48'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom));
        w.tprof = p;
        w.tslot = s;
        w.tvalue = v;
        w.turg = u;
        w.tcher = ch;
        return w;
    endfunction

    // Random profile threshold or class probability, with an occasional
    // out-of-range probability that the shaper must saturate.
    function automatic shaper_word_t random_table_word();
        if ($urandom_range(0, 1) == 0)
            return table_word(CMD_LOAD_PROF, 2'($urandom), 3'($urandom),
                              $urandom_range(0, 32'h0200_0000), 8'($urandom),
                              8'($urandom));
        return table_word(CMD_LOAD_CLASS, 2'($urandom), 3'($urandom),
                          ($urandom_range(0, 15) == 0) ? $urandom
                                                       : $urandom_range(0, 16'hFFFF),
                          8'($urandom), 8'($urandom));
    endfunction

    // Mostly well-formed traffic: moving time, legal queue lengths and a
    // mix of arrivals, serve events and table loads, with some noise on top.
    function automatic shaper_word_t random_word();
        logic [15:0] pdu;
        logic [7:0]  ql;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return random_table_word();
        case ($urandom_range(0, 19))
            0:       clock_ticks = 48'({$urandom, $urandom});
            1, 2:    clock_ticks = clock_ticks;
            default: clock_ticks = clock_ticks + 48'($urandom_range(1, 3000));
        endcase
        if (pick < 45) return traffic_word(CMD_SERVE, 16'($urandom), clock_ticks,
                                           8'($urandom), 16'($urandom), 16'($urandom));
        case ($urandom_range(0, 9))
            0:       pdu = 16'hFFFF;
            1:       pdu = 16'($urandom);
            default: pdu = 16'($urandom_range(0, 12000));
        endcase
        if ($urandom_range(0, 9) == 0 || qlen_limit == 0)
            ql = 8'($urandom_range(0, 128));
        else
            ql = 8'($urandom_range(0, int'(qlen_limit) - 1));
        return traffic_word(CMD_ARRIVE, pdu, clock_ticks, ql, 16'($urandom),
                            16'($urandom));
    endfunction

    // Receiver side: random stall bursts, none once quiet is set.
    always @(negedge aclk) begin
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rdy_hold <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge aclk) begin
        shaper_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word, status %0d", m_tuser);
            end else begin
                e = expected_words[0];
                expected_words.delete(0);
                if (m_tuser != e.status || m_tdata[7:0] != e.urgency ||
                    m_tdata[15:8] != e.cherish || m_tdata[16] != e.dly_valid ||
                    m_tdata[79:17] != e.dly) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result mismatch: expected st %0d urg %0h ",
                                  "cher %0h dv %0d dly %0h, got st %0d urg %0h ",
                                  "cher %0h dv %0d dly %0h"},
                                 e.status, e.urgency, e.cherish, e.dly_valid, e.dly,
                                 m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[16],
                                 m_tdata[79:17]);
                end else if (e.status == ST_RELEASED) begin
                    n_released++;
                end
            end
        end
    end

    // Watchdog: too long with nothing moving on any channel ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIM) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        shaper_word_t w;
        shaper_word_t directed [$];
        status_t      typed_st [$];
        bit           typed_on [$];

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Serving an empty queue right after reset returns nothing released.
        send_word(traffic_word(CMD_SERVE, 16'd0, 48'd0, 8'd0, 16'd0, 16'd0),
                  1'b1, ST_NONE);

        // Fill both tables completely so no traffic ever meets an unloaded
        // entry; later loads only overwrite.
        for (int p = 0; p < N_PROF; p++) begin
            send_word(table_word(CMD_LOAD_PROF, 2'(p), 3'($urandom),
                                 32'(p + 1) * 32'h0040_0000, 8'd0, 8'd0));
            for (int c = 0; c < N_CLASS; c++)
                send_word(table_word(CMD_LOAD_CLASS, 2'(p), 3'(c),
                                     $urandom_range(0, 16'h4000),
                                     8'($urandom), 8'($urandom)));
        end

        // Directed rows: a full queue length drops, field extremes, a
        // timestamp wrap, serving until empty, a saturated probability, the
        // widest class count and a zero window span.
        directed.insert(directed.size(), traffic_word(CMD_ARRIVE, 16'd100, 48'd10,
                                                      8'd128, 16'd0, 16'd0));
        typed_st.insert(typed_st.size(), ST_DROPPED);
        typed_on.insert(typed_on.size(), 1'b1);
        directed.insert(directed.size(), traffic_word(CMD_ARRIVE, 16'd0, 48'd100,
                                                      8'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), traffic_word(CMD_ARRIVE, 16'hFFFF, 48'd100,
                                                      8'd99, 16'hFFFF, 16'hFFFF));
        directed.insert(directed.size(), traffic_word(CMD_ARRIVE, 16'd1000,
                                                      48'hFFFF_FFFF_FFFF, 8'd1,
                                                      16'h8000, 16'h0001));
        directed.insert(directed.size(), traffic_word(CMD_ARRIVE, 16'd1000, 48'd5,
                                                      8'd2, 16'h0001, 16'h8000));
        for (int i = 0; i < 5; i++)
            directed.insert(directed.size(), traffic_word(CMD_SERVE, 16'd0, 48'd6,
                                                          8'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), table_word(CMD_LOAD_CLASS, 2'd0, 3'd7,
                                                    32'hFFFF_FFFF, 8'hFF, 8'hFF));
        directed.insert(directed.size(), table_word(CMD_LOAD_PROF, 2'd0, 3'd7,
                                                    32'hFFFF_FFFF, 8'd0, 8'd0));
        for (int i = 0; i < 12; i++)
            directed.insert(directed.size(),
                            traffic_word(CMD_ARRIVE, 16'(i * 700), 48'd200,
                                         8'(i), 16'($urandom), 16'hFFFF));
        while (typed_on.size() < directed.size()) begin
            typed_on.insert(typed_on.size(), 1'b0);
            typed_st.insert(typed_st.size(), ST_NONE);
        end
        foreach (directed[i])
            send_word(directed[i], typed_on[i], typed_st[i]);
        drain();

        clock_ticks = 48'd1000;
        // Settings walk: high and low settings of every register, out-of-range
        // window and profile counts that the shaper clamps, random ones, then a quiet run.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_all(16'd0, 8'd128, 63'h7FFF_FFFF_FFFF_FFFF, 4'd4,
                             32'd0, 32'hFFFF_FFFF, 3'd4);
                1: write_all(16'hFFFF, 8'd1, 63'd0, 4'd15, 32'hFFFF_FFFF,
                             32'd0, 3'd1);
                2: write_all(16'd8, 8'd100, 63'd16777216000000, 4'd0,
                             32'd15099494, 32'd18454938, 3'd0);
                3: write_all(16'($urandom_range(0, 200)), 8'($urandom_range(20, 128)),
                             63'({$urandom, $urandom} >> 20), 4'($urandom),
                             $urandom_range(0, 32'h0200_0000),
                             $urandom_range(0, 32'h0200_0000), 3'd7);
                4: write_all(16'($urandom), 8'($urandom_range(1, 128)),
                             63'h0000_7FFF_FFFF_FFFF, 4'd3, $urandom_range(0, 32'h0100_0000),
                             $urandom_range(0, 32'h0400_0000), 3'($urandom_range(2, 6)));
                default: begin
                    quiet = 1'b1;
                    write_all(16'd8, 8'd128, 63'h7FFF_FFFF_FFFF_FFFF, 4'd10,
                              32'd15099494, 32'd18454938, 3'd4);
                end
            endcase
            for (int i = 0; i < 70; i++) begin
                if (i == 35) drain();
                send_word(random_word());
            end
            drain();
        end

        $display("Covered %0d arrivals (%0d dropped) and %0d released packets",
                 n_arrivals, n_drops, n_released);
        $display("over six register settings, with table reloads and clamped limits.");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     expected_words.size());
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rcs_pkg.sv
rtl/rcs_queue_mem.sv
rtl/rcs_class_mem.sv
rtl/rcs_rate_div.sv
rtl/rate_adaptive_class_shaper.sv
rtl/rcs_checker.sv
tb/tb_top.sv
